// File: hdl/lcab_pkg.sv
package lcab_pkg;

    // Field widths
    localparam int IDX_W   = 10;
    localparam int DEPTH_W = 10;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Depth saturates here; "none" answer code
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;
    localparam logic [IDX_W-1:0]   NONE_CODE = 10'd1023;

    // Ancestor table entry: present flag plus node index (all zero = no ancestor)
    typedef struct packed {
        logic             present;
        logic [IDX_W-1:0] idx;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    // Request payload
    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] node_a;
        logic [IDX_W-1:0] node_b;
        logic             has_parent;
    } t_req;

    // Response payload
    typedef struct packed {
        logic [IDX_W-1:0] ancestor;
    } t_rsp;

endpackage

// File: hdl/lcab_if.sv
// Request channel
interface lcab_req_if;
    import lcab_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Response channel
interface lcab_rsp_if;
    import lcab_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/lcab_ram.sv
module lcab_ram #(
    parameter int WIDTH  = 11,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    output logic [WIDTH-1:0]  o_rdata_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hdl/lowest_common_ancestor_binary_lifting.sv
// Lowest common ancestor engine over a binary-lifting ancestor table.
// Requests arrive on i_req (valid/ready), answers leave on o_rsp.
// cmd = load enters node_a with parent node_b (or as a root when has_parent
// is low); parents must be loaded before their children. A load gives no
// response; it writes the depth with level zero, then does one table read and
// one write per further level. A root load clears every level, depth zero.
// cmd = query returns the common ancestor of node_a and node_b, or 1023 when
// there is none. A query reads both depths, lifts the deeper node by the depth
// difference, then, unless the lift already meets, descends level by level and
// reads the parent; the single table memory has two registered read ports.
// One request is worked on at a time; i_req.ready is high while the engine
// waits for work. The answer sits in an output register, so the next request
// is taken while o_rsp is stalled; a finished query waits until that register
// frees up. Reset clears the control state only: the table and depth memories
// hold nothing defined until nodes are loaded, and no clearing pass is run.
module lowest_common_ancestor_binary_lifting #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 11
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcab_req_if.sink   i_req,
    lcab_rsp_if.source o_rsp
);
    import lcab_pkg::*;

    localparam int AW      = $clog2(MAX_NODES);
    localparam int LW      = $clog2(LEVELS);
    localparam int TAB_DEP = LEVELS * (2 ** AW);
    localparam int TAB_AW  = LW + AW;
    localparam logic [16:0]   MAX_N    = 17'(MAX_NODES);
    localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LD_ROOT, S_LD_DEP, S_LD_RD, S_LD_WR,
        S_Q_DEP, S_Q_UP, S_Q_UPW, S_Q_CHK, S_Q_DN, S_Q_DNW,
        S_Q_FIN, S_Q_FINW, S_OUT
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_a;
    logic [IDX_W-1:0]    r_b;
    t_entry              r_w;
    t_entry              r_u;
    t_entry              r_v;
    logic                r_uok;
    logic                r_vok;
    logic [LW-1:0]       r_lvl;
    logic [DEPTH_W-1:0]  r_diff;
    logic [IDX_W-1:0]    r_res;
    logic                r_ovalid;
    logic [IDX_W-1:0]    r_anc;

    logic                tab_we;
    logic [TAB_AW-1:0]   tab_waddr;
    t_entry              tab_wdata;
    logic [TAB_AW-1:0]   tab_ra;
    logic [TAB_AW-1:0]   tab_rb;
    logic [ENT_W-1:0]    tab_rd_a;
    logic [ENT_W-1:0]    tab_rd_b;
    logic                dep_we;
    logic [AW-1:0]       dep_waddr;
    logic [DEPTH_W-1:0]  dep_wdata;
    logic [AW-1:0]       dep_ra;
    logic [AW-1:0]       dep_rb;
    logic [DEPTH_W-1:0]  dep_rd_a;
    logic [DEPTH_W-1:0]  dep_rd_b;

    logic                n_uok;
    logic                n_vok;
    t_entry              pa;
    t_entry              pb;
    logic                out_free;

    // Node index to memory address
    function automatic logic [AW-1:0] node_addr(input logic [IDX_W-1:0] idx);
        logic [16:0] ext;
        ext = {7'd0, idx};
        return ext[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return {7'd0, idx} < MAX_N;
    endfunction

    function automatic logic [TAB_AW-1:0] tab_addr(input logic [LW-1:0] lvl,
                                                   input logic [IDX_W-1:0] idx);
        return {lvl, node_addr(idx)};
    endfunction

    // Walker entries that can be lifted
    assign n_uok = r_u.present && in_range(r_u.idx);
    assign n_vok = r_v.present && in_range(r_v.idx);

    // Lifted values: a walker that is off a root stays off it
    assign pa = r_uok ? t_entry'(tab_rd_a) : '0;
    assign pb = r_vok ? t_entry'(tab_rd_b) : '0;

    assign out_free      = !r_ovalid || o_rsp.ready;
    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.data.ancestor = r_anc;

    // Memory addressing per state
    always_comb begin
        tab_we    = 1'b0;
        tab_waddr = tab_addr(r_lvl, r_a);
        tab_wdata = '0;
        tab_ra    = tab_addr(r_lvl, r_u.idx);
        tab_rb    = tab_addr(r_lvl, r_v.idx);
        dep_we    = 1'b0;
        dep_waddr = node_addr(r_a);
        dep_wdata = '0;
        dep_ra    = node_addr(i_req.data.node_a);
        dep_rb    = node_addr(i_req.data.node_b);
        case (r_state)
            S_IDLE: begin
                if (i_req.data.cmd == CMD_LOAD) begin
                    dep_ra = node_addr(i_req.data.node_b);
                end
            end
            S_LD_ROOT: begin
                tab_we = 1'b1;
                if (r_lvl == '0) begin
                    dep_we = 1'b1;
                end
            end
            S_LD_DEP: begin
                dep_we    = 1'b1;
                dep_wdata = (dep_rd_a == DEPTH_MAX) ? DEPTH_MAX : dep_rd_a + 1'b1;
                tab_we    = 1'b1;
                tab_waddr = tab_addr('0, r_a);
                tab_wdata = '{present: 1'b1, idx: r_b};
            end
            S_LD_RD: begin
                tab_ra = tab_addr(r_lvl - LW'(1), r_w.idx);
            end
            S_LD_WR: begin
                tab_we    = 1'b1;
                tab_wdata = pa;
            end
            S_Q_UP: begin
                tab_ra = tab_addr(r_lvl, r_v.idx);
            end
            S_Q_FIN: begin
                tab_ra = tab_addr('0, r_u.idx);
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // output register: load a finished answer, else drop a taken one
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_a <= i_req.data.node_a;
                    r_b <= i_req.data.node_b;
                    if (i_req.valid) begin
                        if (i_req.data.cmd == CMD_LOAD) begin
                            r_lvl <= '0;
                            if (!in_range(i_req.data.node_a)) begin
                                r_state <= S_IDLE;
                            end else if (i_req.data.has_parent
                                         && in_range(i_req.data.node_b)) begin
                                r_state <= S_LD_DEP;
                            end else begin
                                r_state <= S_LD_ROOT;
                            end
                        end else if (!in_range(i_req.data.node_a)
                                     || !in_range(i_req.data.node_b)) begin
                            r_res   <= NONE_CODE;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_Q_DEP;
                        end
                    end
                end
                // root load: clear every level, depth zero
                S_LD_ROOT: begin
                    if (r_lvl == LVL_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_lvl <= r_lvl + 1'b1;
                    end
                end
                S_LD_DEP: begin
                    r_w     <= '{present: 1'b1, idx: r_b};
                    r_lvl   <= LW'(1);
                    r_state <= S_LD_RD;
                end
                S_LD_RD: begin
                    r_uok   <= r_w.present && in_range(r_w.idx);
                    r_state <= S_LD_WR;
                end
                S_LD_WR: begin
                    r_w <= pa;
                    if (r_lvl == LVL_LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_lvl   <= r_lvl + 1'b1;
                        r_state <= S_LD_RD;
                    end
                end
                // order by depth, v is the deeper walker
                S_Q_DEP: begin
                    r_lvl <= '0;
                    if (dep_rd_a > dep_rd_b) begin
                        r_u    <= '{present: 1'b1, idx: r_b};
                        r_v    <= '{present: 1'b1, idx: r_a};
                        r_diff <= dep_rd_a - dep_rd_b;
                    end else begin
                        r_u    <= '{present: 1'b1, idx: r_a};
                        r_v    <= '{present: 1'b1, idx: r_b};
                        r_diff <= dep_rd_b - dep_rd_a;
                    end
                    r_state <= S_Q_UP;
                end
                // lift v by the depth difference, one bit per level
                S_Q_UP: begin
                    r_vok <= n_vok;
                    if (r_diff[0]) begin
                        r_state <= S_Q_UPW;
                    end else begin
                        r_diff <= r_diff >> 1;
                        if (r_lvl == LVL_LAST) begin
                            r_state <= S_Q_CHK;
                        end else begin
                            r_lvl <= r_lvl + 1'b1;
                        end
                    end
                end
                S_Q_UPW: begin
                    r_v    <= r_vok ? t_entry'(tab_rd_a) : '0;
                    r_diff <= r_diff >> 1;
                    if (r_lvl == LVL_LAST) begin
                        r_state <= S_Q_CHK;
                    end else begin
                        r_lvl   <= r_lvl + 1'b1;
                        r_state <= S_Q_UP;
                    end
                end
                S_Q_CHK: begin
                    r_lvl <= LVL_LAST;
                    if (r_u == r_v) begin
                        r_res   <= r_u.present ? r_u.idx : NONE_CODE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_Q_DN;
                    end
                end
                // descend from the top level, move both while they differ
                S_Q_DN: begin
                    r_uok   <= n_uok;
                    r_vok   <= n_vok;
                    r_state <= S_Q_DNW;
                end
                S_Q_DNW: begin
                    if (pa != pb) begin
                        r_u <= pa;
                        r_v <= pb;
                    end
                    if (r_lvl == '0) begin
                        r_state <= S_Q_FIN;
                    end else begin
                        r_lvl   <= r_lvl - 1'b1;
                        r_state <= S_Q_DN;
                    end
                end
                S_Q_FIN: begin
                    r_uok   <= n_uok;
                    r_state <= S_Q_FINW;
                end
                S_Q_FINW: begin
                    r_res   <= pa.present ? pa.idx : NONE_CODE;
                    r_state <= S_OUT;
                end
                // hand the answer to the output register
                S_OUT: begin
                    if (out_free) begin
                        r_anc   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Ancestor table: level in the high address bits, node in the low bits
    lcab_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (TAB_DEP),
        .ADDR_W (TAB_AW)
    ) u_tab_ram (
        .i_clk     (i_clk),
        .i_we      (tab_we),
        .i_waddr   (tab_waddr),
        .i_wdata   (tab_wdata),
        .i_raddr_a (tab_ra),
        .o_rdata_a (tab_rd_a),
        .i_raddr_b (tab_rb),
        .o_rdata_b (tab_rd_b)
    );

    // Node depth memory
    lcab_ram #(
        .WIDTH  (DEPTH_W),
        .DEPTH  (2 ** AW),
        .ADDR_W (AW)
    ) u_dep_ram (
        .i_clk     (i_clk),
        .i_we      (dep_we),
        .i_waddr   (dep_waddr),
        .i_wdata   (dep_wdata),
        .i_raddr_a (dep_ra),
        .o_rdata_a (dep_rd_a),
        .i_raddr_b (dep_rb),
        .o_rdata_b (dep_rd_b)
    );

endmodule
